// File: design/resc_pkg.sv
// Shared field widths, action codes and register indexes for the scan converter.
package resc_pkg;

   // Transfer field widths
   localparam int ACTION_W   = 3;
   localparam int ADDR_W     = 19;
   localparam int OFFSET_W   = 20;
   localparam int COORD_W    = 9;
   localparam int ANGLE_W    = 9;
   localparam int BIN_W      = 8;
   localparam int ECHO_W     = 9;
   localparam int PIXEL_W    = 8;
   localparam int COUNT_W    = 20;
   localparam int POINT_W    = 2 * COORD_W;

   // Register port
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 10;
   localparam int SWEEP_REG_W  = 9;
   localparam int ANGLE_REG_W  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_COUNT = 1'b1;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD_OFFSET = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_POINT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ECHO        = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ_PIXEL  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WRITE_PIXEL = 3'd4;

endpackage

// File: design/resc_image_ram.sv
// Image store: synchronous RAM with registered read and write-to-read forwarding.
module resc_image_ram #(
   parameter int DEPTH = 262144
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_pos,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_pos,
   input  logic [resc_pkg::PIXEL_W-1:0] wr_data,
   output logic [resc_pkg::PIXEL_W-1:0] rd_data
);
   import resc_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_ff;
   logic [AW-1:0]      rd_pos_ff;
   logic               fwd_valid_ff;
   logic [AW-1:0]      fwd_pos_ff;
   logic [PIXEL_W-1:0] fwd_data_ff;

   // Array write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_pos] <= wr_data;
      end
   end

   // Registered read; a write on the same edge is not yet visible here
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff     <= mem[rd_pos];
         rd_pos_ff <= rd_pos;
      end
   end

   // Remember the write of the read edge so it can bypass stale data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_pos_ff  <= wr_pos;
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = (fwd_valid_ff && (fwd_pos_ff == rd_pos_ff)) ? fwd_data_ff : rd_ff;

endmodule

// File: design/radar_echo_scan_converter.sv
// Radar echo scan converter top level: table loads, echo pixel walk, pixel access.
//
// Each request transfer returns exactly one response transfer. Echo time is set by
// the pixel walk: one point-table read and one image read-modify-write per cycle,
// pipelined over three stages with forwarding in the image RAM; the cell lookup
// costs a multiply and two offset-table reads ahead of it. The next request is taken
// while the last response is still waiting on rsp_ready. Tables and image start
// undefined; software must load them before they are read; the block does not
// enforce this.
module radar_echo_scan_converter #(
   parameter int MAX_ANGLES = 512,
   parameter int MAX_SWEEP  = 256,
   parameter int WINDOW     = 512,
   parameter int MAX_POINTS = 524288
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [resc_pkg::ACTION_W-1:0]         req_action,
   input  logic [resc_pkg::ADDR_W-1:0]           req_table_address,
   input  logic [resc_pkg::OFFSET_W-1:0]         req_offset_value,
   input  logic [resc_pkg::COORD_W-1:0]          req_pixel_x,
   input  logic [resc_pkg::COORD_W-1:0]          req_pixel_y,
   input  logic [resc_pkg::ANGLE_W-1:0]          req_angle,
   input  logic [resc_pkg::BIN_W-1:0]            req_range_bin,
   input  logic signed [resc_pkg::ECHO_W-1:0]    req_echo_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_status,
   output logic [resc_pkg::PIXEL_W-1:0]          rsp_pixel_value,
   output logic [resc_pkg::COUNT_W-1:0]          rsp_pixels_updated,
   // register port
   input  logic                                  csr_we,
   input  logic [resc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [resc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import resc_pkg::*;

   localparam int OFF_DEPTH = MAX_ANGLES * MAX_SWEEP + 1;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int PT_AW     = $clog2(MAX_POINTS);
   localparam int PT_CW     = $clog2(MAX_POINTS + 1);
   localparam int IMG_DEPTH = WINDOW * WINDOW;
   localparam int IMG_AW    = $clog2(IMG_DEPTH);
   localparam int SW_W      = $clog2(MAX_SWEEP + 1);
   localparam int AC_W      = $clog2(MAX_ANGLES + 1);
   localparam int PROD_W    = ANGLE_W + SW_W;
   localparam int SWEEP_RST = (256 > MAX_SWEEP) ? MAX_SWEEP : 256;
   localparam int ANGLE_RST = (512 > MAX_ANGLES) ? MAX_ANGLES : 512;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EXEC   = 8'b0000_0010,
      ST_CELL   = 8'b0000_0100,
      ST_OFFB   = 8'b0000_1000,
      ST_OFFE   = 8'b0001_0000,
      ST_WALK   = 8'b0010_0000,
      ST_RDWAIT = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SW_W-1:0] sweep_ff;
   logic [AC_W-1:0] angle_ff;

   // captured request
   logic [ACTION_W-1:0] act_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [OFFSET_W-1:0] offv_ff;
   logic [COORD_W-1:0]  px_ff, py_ff;
   logic [ANGLE_W-1:0]  ang_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic [PIXEL_W-1:0]  echo_ff, echo_in;

   // echo cell lookup and walk
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [OFF_AW-1:0]   cell_ff, cell_in;
   logic [PT_CW-1:0]    beg_ff, beg_in;
   logic [PT_CW-1:0]    end_ff, end_in;
   logic [PT_CW-1:0]    id_ff, id_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_inwin_ff, s2_inwin_in;
   logic [IMG_AW-1:0]   s2_pos_ff, s2_pos_in;

   // result being built, and the response register
   logic                res_status_ff, res_status_in;
   logic [PIXEL_W-1:0]  res_pixel_ff, res_pixel_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // table memories
   logic [OFFSET_W-1:0] offset_mem [OFF_DEPTH];
   logic [POINT_W-1:0]  point_mem [MAX_POINTS];
   logic [OFFSET_W-1:0] off_rd_ff;
   logic [POINT_W-1:0]  pt_rd_ff;
   logic                off_we, off_re, pt_we, pt_re;
   logic [OFF_AW-1:0]   off_waddr, off_raddr;
   logic [PT_AW-1:0]    pt_waddr, pt_raddr;

   // image port
   logic                img_rd_en, img_wr_en;
   logic [IMG_AW-1:0]   img_rd_pos, img_wr_pos;
   logic [PIXEL_W-1:0]  img_wr_data, img_rd_data;

   // decode helpers
   logic [31:0]         addr32, pix_pos32, cell_sum32, walk_pos32;
   logic                off_addr_ok, pt_addr_ok, pix_ok, cell_ok;
   logic [IMG_AW-1:0]   pix_pos, walk_pos;
   logic                walk_inwin, issue;
   logic [COORD_W-1:0]  walk_x, walk_y;
   logic [PT_CW-1:0]    off_sat;
   logic [PIXEL_W-1:0]  pix_max;

   // Negative echo clamps to zero
   assign echo_in = req_echo_value[ECHO_W-1] ? '0 : req_echo_value[PIXEL_W-1:0];

   // Request capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff  <= req_action;
         addr_ff <= req_table_address;
         offv_ff <= req_offset_value;
         px_ff   <= req_pixel_x;
         py_ff   <= req_pixel_y;
         ang_ff  <= req_angle;
         bin_ff  <= req_range_bin;
         echo_ff <= echo_in;
      end
   end

   // Register writes saturate into 1..max
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= SW_W'(SWEEP_RST);
         angle_ff <= AC_W'(ANGLE_RST);
      end else if (csr_we) begin
         if (csr_index == CSR_SWEEP_SIZE) begin
            if (csr_wdata[SWEEP_REG_W-1:0] == '0) begin
               sweep_ff <= SW_W'(1);
            end else if (32'(csr_wdata[SWEEP_REG_W-1:0]) > 32'(MAX_SWEEP)) begin
               sweep_ff <= SW_W'(MAX_SWEEP);
            end else begin
               sweep_ff <= SW_W'(csr_wdata[SWEEP_REG_W-1:0]);
            end
         end else if (csr_index == CSR_ANGLE_COUNT) begin
            if (csr_wdata[ANGLE_REG_W-1:0] == '0) begin
               angle_ff <= AC_W'(1);
            end else if (32'(csr_wdata[ANGLE_REG_W-1:0]) > 32'(MAX_ANGLES)) begin
               angle_ff <= AC_W'(MAX_ANGLES);
            end else begin
               angle_ff <= AC_W'(csr_wdata[ANGLE_REG_W-1:0]);
            end
         end
      end
   end

   // Range checks and addresses from the captured request
   assign addr32      = 32'(addr_ff);
   assign off_addr_ok = addr32 < 32'(OFF_DEPTH);
   assign pt_addr_ok  = addr32 < 32'(MAX_POINTS);
   assign pix_ok      = (32'(px_ff) < 32'(WINDOW)) && (32'(py_ff) < 32'(WINDOW));
   assign cell_ok     = (32'(ang_ff) < 32'(angle_ff)) && (32'(bin_ff) < 32'(sweep_ff));
   assign off_waddr   = addr32[OFF_AW-1:0];
   assign pt_waddr    = addr32[PT_AW-1:0];
   assign pix_pos32   = 32'(py_ff) * 32'(WINDOW) + 32'(px_ff);
   assign pix_pos     = pix_pos32[IMG_AW-1:0];
   assign cell_sum32  = 32'(prod_ff) + 32'(bin_ff);

   // Walk stage 1: point data to image position
   assign walk_x      = pt_rd_ff[COORD_W-1:0];
   assign walk_y      = pt_rd_ff[POINT_W-1:COORD_W];
   assign walk_inwin  = (32'(walk_x) < 32'(WINDOW)) && (32'(walk_y) < 32'(WINDOW));
   assign walk_pos32  = 32'(walk_y) * 32'(WINDOW) + 32'(walk_x);
   assign walk_pos    = walk_pos32[IMG_AW-1:0];
   assign issue       = id_ff < end_ff;
   assign pt_raddr    = id_ff[PT_AW-1:0];

   // Walk stage 2: keep the brighter of old pixel and echo
   assign pix_max     = (echo_ff > img_rd_data) ? echo_ff : img_rd_data;

   // Offset entries beyond the point table saturate
   assign off_sat = (32'(off_rd_ff) > 32'(MAX_POINTS)) ? PT_CW'(MAX_POINTS)
                                                        : PT_CW'(off_rd_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      prod_in       = prod_ff;
      cell_in       = cell_ff;
      beg_in        = beg_ff;
      end_in        = end_ff;
      id_in         = id_ff;
      s1_valid_in   = 1'b0;
      s2_valid_in   = 1'b0;
      s2_inwin_in   = s2_inwin_ff;
      s2_pos_in     = s2_pos_ff;
      res_status_in = res_status_ff;
      res_pixel_in  = res_pixel_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_count_in  = rsp_count_ff;
      off_we        = 1'b0;
      off_re        = 1'b0;
      off_raddr     = cell_ff;
      pt_we         = 1'b0;
      pt_re         = 1'b0;
      img_rd_en     = 1'b0;
      img_rd_pos    = pix_pos;
      img_wr_en     = 1'b0;
      img_wr_pos    = pix_pos;
      img_wr_data   = echo_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = 1'b0;
            res_pixel_in  = '0;
            res_count_in  = '0;
            state_in      = ST_FINISH;
            case (act_ff)
               ACT_LOAD_OFFSET: begin
                  if (off_addr_ok) begin
                     off_we = 1'b1;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               ACT_LOAD_POINT: begin
                  if (pt_addr_ok && pix_ok) begin
                     pt_we = 1'b1;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               ACT_ECHO: begin
                  if (cell_ok) begin
                     prod_in  = PROD_W'(ang_ff) * PROD_W'(sweep_ff);
                     state_in = ST_CELL;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               ACT_READ_PIXEL: begin
                  if (pix_ok) begin
                     img_rd_en = 1'b1;
                     state_in  = ST_RDWAIT;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               ACT_WRITE_PIXEL: begin
                  if (pix_ok) begin
                     img_wr_en = 1'b1;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               default: begin
                  res_status_in = 1'b1;
               end
            endcase
         end
         ST_CELL: begin
            off_re    = 1'b1;
            off_raddr = cell_sum32[OFF_AW-1:0];
            cell_in   = cell_sum32[OFF_AW-1:0];
            state_in  = ST_OFFB;
         end
         ST_OFFB: begin
            // start offset arrives, fetch the end entry
            off_re    = 1'b1;
            off_raddr = cell_ff + OFF_AW'(1);
            beg_in    = off_sat;
            state_in  = ST_OFFE;
         end
         ST_OFFE: begin
            end_in = off_sat;
            id_in  = beg_ff;
            if (off_sat > beg_ff) begin
               res_count_in = COUNT_W'(off_sat - beg_ff);
            end else begin
               res_count_in = '0;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (issue) begin
               pt_re       = 1'b1;
               id_in       = id_ff + PT_CW'(1);
               s1_valid_in = 1'b1;
            end
            img_rd_en   = s1_valid_ff;
            img_rd_pos  = walk_pos;
            s2_valid_in = s1_valid_ff;
            s2_inwin_in = walk_inwin;
            s2_pos_in   = walk_pos;
            img_wr_en   = s2_valid_ff && s2_inwin_ff;
            img_wr_pos  = s2_pos_ff;
            img_wr_data = pix_max;
            // last write retires on this edge
            if (!issue && !s1_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_RDWAIT: begin
            res_pixel_in = img_rd_data;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pixel_in  = res_pixel_ff;
               rsp_count_in  = res_count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      cell_ff       <= cell_in;
      beg_ff        <= beg_in;
      end_ff        <= end_in;
      id_ff         <= id_in;
      s2_inwin_ff   <= s2_inwin_in;
      s2_pos_ff     <= s2_pos_in;
      res_status_ff <= res_status_in;
      res_pixel_ff  <= res_pixel_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Offset table
   always_ff @(posedge clock) begin
      if (off_we) begin
         offset_mem[off_waddr] <= offv_ff;
      end
      if (off_re) begin
         off_rd_ff <= offset_mem[off_raddr];
      end
   end

   // Point table, entries packed as {row, column}
   always_ff @(posedge clock) begin
      if (pt_we) begin
         point_mem[pt_waddr] <= {py_ff, px_ff};
      end
      if (pt_re) begin
         pt_rd_ff <= point_mem[pt_raddr];
      end
   end

   resc_image_ram #(
      .DEPTH(IMG_DEPTH)
   ) u_image (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (img_rd_en),
      .rd_pos  (img_rd_pos),
      .wr_en   (img_wr_en),
      .wr_pos  (img_wr_pos),
      .wr_data (img_wr_data),
      .rd_data (img_rd_data)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pixel_value    = rsp_pixel_ff;
   assign rsp_pixels_updated = rsp_count_ff;

   // Walk index never runs past the list end; a list whose end is not above
   // its start leaves the index parked at the start
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((id_ff <= end_ff) || (id_ff == beg_ff)))
      else $error("pixel walk index past list end");

   // One request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // Walk pipeline stages only live inside the walk
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (state_ff == ST_WALK))
      else $error("walk stage active outside walk");

   // Finished result reaches the response register and frees the block
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready))
         |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("result not delivered");

endmodule
